### src/bss_pkg.sv
// Shared types and constants for the bounded stack with search.
package bss_pkg;

	localparam int DATA_W   = 32;
	localparam int STATUS_W = 3;
	localparam int POS_W    = 6;
	localparam int LIMIT_W  = 7;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

	localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] STS_OVERFLOW  = 3'd1;
	localparam logic [STATUS_W-1:0] STS_UNDERFLOW = 3'd2;
	localparam logic [STATUS_W-1:0] STS_EMPTY     = 3'd3;
	localparam logic [STATUS_W-1:0] STS_FOUND     = 3'd4;
	localparam logic [STATUS_W-1:0] STS_NOTFOUND  = 3'd5;

	typedef enum logic [1:0] {
		ACT_PUSH    = 2'd0,
		ACT_POP     = 2'd1,
		ACT_DISPLAY = 2'd2,
		ACT_SEARCH  = 2'd3
	} act_t;

	typedef struct packed {
		logic [1:0]               action;
		logic signed [DATA_W-1:0] push_value;
		logic signed [DATA_W-1:0] search_key;
	} in_t;

	typedef struct packed {
		logic [STATUS_W-1:0]      status;
		logic signed [DATA_W-1:0] data_out;
		logic [POS_W-1:0]         position;
		logic                     last;
	} out_t;

	typedef struct packed {
		act_t              op;
		logic [DATA_W-1:0] arg;
	} cmd_t;

endpackage

### src/bounded_stack_with_search.sv
// Bounded LIFO stack with top-down search: top level.
// Push, pop, overflow, underflow and empty results pass stage 1 and the output register.
// Display of N entries: walked from the bottom, one result per cycle unless output stalls.
// Search holds the back end while it walks entries top-down until a match or the bottom.
// The 2-entry command queue accepts until full while the back end walks or output stalls.
// Reset clears entry count and queue, sets stack_limit to 64; stack RAM is not cleared.
module bounded_stack_with_search import bss_pkg::*; #(
	parameter int STACK_DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  in_t                in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output out_t               out_data,
	input  logic               cfg_wr_en,
	input  logic [LIMIT_W-1:0] cfg_wr_data
);

	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;

	bss_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop)
	);

	bss_back #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_pop    (cmd_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

endmodule

### src/bss_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### src/bss_front.sv
// Front end: accepts input transactions, decodes the action and queues commands.
module bss_front import bss_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  in_t  in_data,
	output logic cmd_valid,
	output cmd_t cmd,
	input  logic cmd_pop
);

	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	cmd_t       queue_q [2];
	cmd_t       cmd_new;
	logic       push;

	always_comb begin
		cmd_new.op  = act_t'(in_data.action);
		cmd_new.arg = (cmd_new.op == ACT_SEARCH) ? in_data.search_key : in_data.push_value;
	end

	assign in_stall  = (fill_q == 2'd2);
	assign push      = in_valid && !in_stall;
	assign cmd_valid = (fill_q != 2'd0);
	assign cmd       = queue_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !cmd_pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (!push && cmd_pop) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cmd_new;
		end
	end

endmodule

### src/bss_back.sv
// Back end: stack storage, entry count, walk sequencer and output register.
module bss_back import bss_pkg::*; #(
	parameter int STACK_DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [LIMIT_W-1:0] cfg_wr_data,
	input  logic               cmd_valid,
	input  cmd_t               cmd,
	output logic               cmd_pop,
	output logic               out_valid,
	input  logic               out_stall,
	output out_t               out_data
);

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	typedef enum logic [1:0] {
		BK_IDLE = 2'b01,
		BK_WALK = 2'b10
	} bk_state_t;

	bk_state_t           st_q;
	logic [CW-1:0]       count_q;
	logic [LIMIT_W-1:0]  limit_q;
	act_t                kind_q;
	logic [IW-1:0]       idx_q;
	logic [DATA_W-1:0]   key_q;

	logic                v_s1;
	act_t                kind_s1;
	logic                ram_s1;
	logic [STATUS_W-1:0] status_s1;
	logic [IW-1:0]       pos_s1;
	logic                last_s1;

	logic                out_v_q;
	out_t                out_q;
	out_t                out_nxt;

	logic                ram_we;
	logic                ram_re;
	logic [IW-1:0]       ram_waddr;
	logic [IW-1:0]       ram_raddr;
	logic [DATA_W-1:0]   ram_rdata;

	logic [CW-1:0]       count_m1;
	logic [IW-1:0]       top_idx;
	logic                full;
	logic                empty;
	logic                match;
	logic                emit;
	logic                out_free;
	logic                s1_adv;
	logic                s1_free;
	logic                term;
	logic                take;
	logic                take_res;
	logic                walk_last;
	logic                walk_fire;
	logic                is_scan;

	bss_ram #(
		.WIDTH(DATA_W),
		.DEPTH(STACK_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(cmd.arg),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign count_m1 = count_q - CW'(1);
	assign top_idx  = count_m1[IW-1:0];
	assign full     = (LIMIT_W'(count_q) >= limit_q) || (count_q == CW'(STACK_DEPTH));
	assign empty    = (count_q == '0);
	assign match    = (ram_rdata == key_q);

	assign emit     = v_s1 && (!(ram_s1 && kind_s1 == ACT_SEARCH) || match || last_s1);
	assign out_free = !out_v_q || !out_stall;
	assign s1_adv   = v_s1 && (!emit || out_free);
	assign s1_free  = !v_s1 || s1_adv;
	assign term     = s1_adv && ram_s1 && (kind_s1 == ACT_SEARCH) && match;

	assign is_scan  = (cmd.op == ACT_DISPLAY) || (cmd.op == ACT_SEARCH);
	assign take     = (st_q == BK_IDLE) && cmd_valid && s1_free;
	assign take_res = take && !(is_scan && !empty);
	assign cmd_pop  = take;

	assign walk_last = (kind_q == ACT_SEARCH) ? (idx_q == '0) : (CW'(idx_q) == count_m1);
	assign walk_fire = (st_q == BK_WALK) && s1_free && !term;

	assign ram_we    = take && (cmd.op == ACT_PUSH) && !full;
	assign ram_waddr = count_q[IW-1:0];
	assign ram_re    = walk_fire || (take && (cmd.op == ACT_POP) && !empty);
	assign ram_raddr = walk_fire ? idx_q : top_idx;

	always_comb begin
		out_nxt          = '0;
		out_nxt.last     = 1'b1;
		out_nxt.status   = status_s1;
		if (ram_s1) begin
			case (kind_s1)
				ACT_POP: begin
					out_nxt.status   = STS_OK;
					out_nxt.data_out = ram_rdata;
				end
				ACT_DISPLAY: begin
					out_nxt.status   = STS_OK;
					out_nxt.data_out = ram_rdata;
					out_nxt.position = POS_W'(pos_s1);
					out_nxt.last     = last_s1;
				end
				ACT_SEARCH: begin
					if (match) begin
						out_nxt.status   = STS_FOUND;
						out_nxt.position = POS_W'(pos_s1);
					end else begin
						out_nxt.status = STS_NOTFOUND;
					end
				end
				default: begin
					out_nxt.status = STS_OK;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= BK_IDLE;
			count_q <= '0;
			limit_q <= LIMIT_RESET;
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
			if (take) begin
				unique case (cmd.op)
					ACT_PUSH: begin
						if (!full) begin
							count_q <= count_q + CW'(1);
						end
					end
					ACT_POP: begin
						if (!empty) begin
							count_q <= count_m1;
						end
					end
					ACT_DISPLAY, ACT_SEARCH: begin
						if (!empty) begin
							st_q <= BK_WALK;
						end
					end
				endcase
			end
			// a match on the final read arrives after the walk has already ended
			if ((walk_fire && walk_last) || (term && st_q == BK_WALK)) begin
				st_q <= BK_IDLE;
			end
			if (take_res || walk_fire) begin
				v_s1 <= 1'b1;
			end else if (s1_adv) begin
				v_s1 <= 1'b0;
			end
			if (out_free) begin
				out_v_q <= s1_adv && emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			kind_q <= cmd.op;
			key_q  <= cmd.arg;
			idx_q  <= (cmd.op == ACT_SEARCH) ? top_idx : '0;
		end else if (walk_fire) begin
			idx_q <= (kind_q == ACT_SEARCH) ? idx_q - IW'(1) : idx_q + IW'(1);
		end
		if (take_res) begin
			kind_s1 <= cmd.op;
			ram_s1  <= (cmd.op == ACT_POP) && !empty;
			pos_s1  <= '0;
			last_s1 <= 1'b1;
			unique case (cmd.op)
				ACT_PUSH:                status_s1 <= full ? STS_OVERFLOW : STS_OK;
				ACT_POP:                 status_s1 <= empty ? STS_UNDERFLOW : STS_OK;
				ACT_DISPLAY, ACT_SEARCH: status_s1 <= STS_EMPTY;
			endcase
		end else if (walk_fire) begin
			kind_s1   <= kind_q;
			ram_s1    <= 1'b1;
			pos_s1    <= idx_q;
			last_s1   <= walk_last;
			status_s1 <= STS_OK;
		end
		if (out_free && s1_adv && emit) begin
			out_q <= out_nxt;
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q;

`ifndef NO_ASSERTIONS
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(take && cmd.op == ACT_PUSH && !full) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("push did not advance entry count");

	a_read_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |-> (CW'(ram_raddr) < count_q))
		else $error("read beyond stored entries");

	a_walk_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == BK_WALK) |-> !empty)
		else $error("walk on empty stack");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> $past(v_s1))
		else $error("output loaded without stage 1 data");
`endif

endmodule
